// ===== sv/iff_pkg.sv =====
// ----------------------------------------------------------------------------
// iff_pkg: shared types and constants of the integer field formatter
// Conversion codes, the number base, the request descriptor that passes
// from the front end to the back end, and the digit character lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package iff_pkg;

	// Conversion codes as they arrive on the request
	localparam logic [2:0] CONV_SDEC = 3'd0;
	localparam logic [2:0] CONV_UDEC = 3'd1;
	localparam logic [2:0] CONV_OCT  = 3'd2;
	localparam logic [2:0] CONV_HEXL = 3'd3;
	localparam logic [2:0] CONV_HEXU = 3'd4;

	// ASCII characters used in the field
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LOW = 8'h61;
	localparam logic [7:0] CH_X_LOW = 8'h78;

	// Entries of the queue between front and back end
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	// Classified request, everything but the magnitude
	typedef struct packed {
		base_t      base;
		logic       upper;
		logic       left;
		logic       zfill;
		logic [5:0] width;
		logic [5:0] prec;
		logic [7:0] pre0;
		logic [7:0] pre1;
		logic [1:0] plen;
	} ctrl_t;

	// Map a digit value to its ASCII character
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = (upper ? CH_A_UP : CH_A_LOW) + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/integer_field_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_field_formatter: printf-style integer field formatter
// Turns one parsed integer conversion into its ASCII characters.
// ----------------------------------------------------------------------------
// Each accepted request is classified on entry and queued (two entries), so
// a new request can be taken while the previous field is still being sent.
// The back end handles one request at a time: it takes it from the queue,
// then converts the magnitude one bit per cycle, followed by the digit count
// and field layout steps (TALLY, PLAN, BOUND), and then the field goes out at
// one character per cycle while the output is not stalled,
// max(width, prefix + max(precision, digits)) characters with last set on the
// final one. A zero value with a given precision of zero produces no
// characters and is dropped at entry. Zero fill applies only without a
// precision and without left alignment; width and precision above
// MAX_WIDTH are clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_field_formatter #(
	parameter int MAX_WIDTH  = 48,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [2:0]            conversion,
	input  wire logic                  left_align,
	input  wire logic                  force_plus,
	input  wire logic                  space_sign,
	input  wire logic                  alt_form,
	input  wire logic                  zero_fill,
	input  wire logic [5:0]            width,
	input  wire logic                  precision_given,
	input  wire logic [5:0]            precision,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 character,
	output logic                       last
);

	localparam int ENTRY_W = $bits(iff_pkg::ctrl_t) + VALUE_BITS;

	iff_pkg::ctrl_t        f_ctrl;
	logic [VALUE_BITS-1:0] f_mag;
	logic                  f_drop;
	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_valid;
	logic [ENTRY_W-1:0]    q_rd_data;
	iff_pkg::ctrl_t        q_ctrl;
	logic [VALUE_BITS-1:0] q_mag;

	// Classify incoming request
	iff_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.value           (value),
		.conversion      (conversion),
		.left_align      (left_align),
		.force_plus      (force_plus),
		.space_sign      (space_sign),
		.alt_form        (alt_form),
		.zero_fill       (zero_fill),
		.width           (width),
		.precision_given (precision_given),
		.precision       (precision),
		.ctrl            (f_ctrl),
		.mag             (f_mag),
		.drop            (f_drop)
	);

	// Accept while the queue has room; drop empty fields
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && !f_drop;

	iff_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (iff_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_ctrl, f_mag}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rd_data)
	);

	assign q_ctrl = q_rd_data[ENTRY_W-1:VALUE_BITS];
	assign q_mag  = q_rd_data[VALUE_BITS-1:0];

	// Convert and emit
	iff_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ctrl    (q_ctrl),
		.q_mag     (q_mag),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== sv/iff_front.sv =====
// ----------------------------------------------------------------------------
// iff_front: request classification
// Saturates width and precision, settles the effective flags, forms the
// magnitude and the sign or alternate-form prefix, and flags requests that
// produce no characters at all.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_front #(
	parameter int MAX_WIDTH  = 48,
	parameter int VALUE_BITS = 32
) (
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [2:0]            conversion,
	input  wire logic                  left_align,
	input  wire logic                  force_plus,
	input  wire logic                  space_sign,
	input  wire logic                  alt_form,
	input  wire logic                  zero_fill,
	input  wire logic [5:0]            width,
	input  wire logic                  precision_given,
	input  wire logic [5:0]            precision,
	output iff_pkg::ctrl_t             ctrl,
	output logic [VALUE_BITS-1:0]      mag,
	output logic                       drop
);

	localparam logic [5:0] MAXW = 6'(MAX_WIDTH);

	logic [5:0] width_sat;
	logic [5:0] prec_sat;

	// Clamp width and precision to the supported field size
	assign width_sat = (width > MAXW) ? MAXW : width;
	assign prec_sat  = (precision > MAXW) ? MAXW : precision;

	// Zero value at zero precision prints nothing
	assign drop = precision_given && (precision == 6'd0) && (value == '0);

	// Classify conversion, flags and prefix
	always_comb begin
		ctrl.base  = iff_pkg::BASE_DEC;
		ctrl.upper = 1'b0;
		ctrl.left  = left_align;
		ctrl.zfill = zero_fill & ~precision_given & ~left_align;
		ctrl.width = width_sat;
		ctrl.prec  = precision_given ? prec_sat : 6'd1;
		ctrl.pre0  = iff_pkg::CH_SPACE;
		ctrl.pre1  = iff_pkg::CH_SPACE;
		ctrl.plen  = 2'd0;
		mag        = value;
		case (conversion)
			iff_pkg::CONV_SDEC: begin
				if (value[VALUE_BITS-1]) begin
					mag       = ~value + VALUE_BITS'(1);
					ctrl.plen = 2'd1;
					ctrl.pre0 = iff_pkg::CH_MINUS;
				end else if (force_plus) begin
					ctrl.plen = 2'd1;
					ctrl.pre0 = iff_pkg::CH_PLUS;
				end else if (space_sign) begin
					ctrl.plen = 2'd1;
					ctrl.pre0 = iff_pkg::CH_SPACE;
				end
			end
			iff_pkg::CONV_UDEC: begin
				ctrl.base = iff_pkg::BASE_DEC;
			end
			iff_pkg::CONV_OCT: begin
				ctrl.base = iff_pkg::BASE_OCT;
				if (alt_form) begin
					ctrl.plen = 2'd1;
					ctrl.pre0 = iff_pkg::CH_ZERO;
				end
			end
			iff_pkg::CONV_HEXL, iff_pkg::CONV_HEXU: begin
				ctrl.base  = iff_pkg::BASE_HEX;
				ctrl.upper = (conversion == iff_pkg::CONV_HEXU);
				if (alt_form) begin
					ctrl.plen = 2'd2;
					ctrl.pre0 = iff_pkg::CH_ZERO;
					ctrl.pre1 = (conversion == iff_pkg::CONV_HEXU) ?
						iff_pkg::CH_X_UP : iff_pkg::CH_X_LOW;
				end
			end
			default: begin
				// undefined codes format as unsigned decimal
				ctrl.base = iff_pkg::BASE_DEC;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/iff_queue.sv =====
// ----------------------------------------------------------------------------
// iff_queue: short request queue
// A small first-in first-out buffer of classified requests that decouples
// the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/iff_back.sv =====
// ----------------------------------------------------------------------------
// iff_back: digit conversion and character emission
// Converts the magnitude bit-serially (shift-add-3 for decimal, plain shift
// for octal and hex), counts significant digits on the way, lays out the
// field regions and emits one character per cycle, unless the output is stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_back #(
	parameter int MAX_WIDTH  = 48,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire iff_pkg::ctrl_t        q_ctrl,
	input  wire logic [VALUE_BITS-1:0] q_mag,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 character,
	output logic                       last
);

	localparam int DIG_MAX = (VALUE_BITS + 2) / 3;
	localparam int ACC_W   = 4 * DIG_MAX;
	localparam int IDX_W   = $clog2(DIG_MAX);
	localparam int ND_W    = $clog2(DIG_MAX + 1);
	localparam int CNT_W   = $clog2(VALUE_BITS);
	localparam int POS_W   = $clog2(MAX_WIDTH + DIG_MAX + 4);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CONV  = 6'b000010,
		ST_TALLY = 6'b000100,
		ST_PLAN  = 6'b001000,
		ST_BOUND = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                  state_q;
	iff_pkg::ctrl_t          ctrl_q;
	logic [VALUE_BITS-1:0]   sh_q;
	logic [ACC_W-1:0]        acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ND_W-1:0]         nd_q;
	logic [POS_W-1:0]        body_q;
	logic [POS_W-1:0]        b0_q;
	logic [POS_W-1:0]        b1_q;
	logic [POS_W-1:0]        b2_q;
	logic [POS_W-1:0]        b3_q;
	logic [POS_W-1:0]        total_q;
	logic [POS_W-1:0]        pos_q;
	logic                    out_valid_q;
	logic [7:0]              char_q;
	logic                    last_q;

	logic [ACC_W-1:0]        acc_adj;
	logic [ACC_W-1:0]        acc_next;
	logic [IDX_W-1:0]        rd_idx;
	logic [POS_W-1:0]        digit_pos;
	logic [3:0]              rd_digit;
	logic                    digit_nz;
	logic                    emit_ok;
	logic                    emit_last;
	logic [7:0]              emit_char;
	logic [POS_W-1:0]        nd_ext;
	logic [POS_W-1:0]        prec_ext;
	logic [POS_W-1:0]        plen_ext;
	logic [POS_W-1:0]        width_ext;
	logic [POS_W-1:0]        zeros;
	logic [POS_W-1:0]        npad;
	logic [POS_W-1:0]        lead;
	logic [POS_W-1:0]        zpad;
	logic [POS_W-1:0]        b3_next;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// Correct BCD nibbles before the shift, decimal only
	always_comb begin
		acc_adj = acc_q;
		if (ctrl_q.base == iff_pkg::BASE_DEC) begin
			for (int k = 0; k < DIG_MAX; k++) begin
				if (acc_q[4*k +: 4] >= 4'd5) begin
					acc_adj[4*k +: 4] = acc_q[4*k +: 4] + 4'd3;
				end
			end
		end
	end

	assign acc_next = {acc_adj[ACC_W-2:0], sh_q[VALUE_BITS-1]};

	// Read one digit: the next candidate while counting, the output digit while emitting
	assign digit_pos = b3_q - pos_q - POS_W'(1);
	assign rd_idx    = (state_q == ST_EMIT) ? digit_pos[IDX_W-1:0] : nd_q[IDX_W-1:0];
	assign rd_digit  = (ctrl_q.base == iff_pkg::BASE_OCT) ?
		{1'b0, acc_q[rd_idx*3 +: 3]} : acc_q[rd_idx*4 +: 4];
	assign digit_nz  = (nd_q < ND_W'(DIG_MAX)) && (rd_digit != 4'd0);

	// Field layout arithmetic
	assign nd_ext    = POS_W'(nd_q);
	assign prec_ext  = POS_W'(ctrl_q.prec);
	assign plen_ext  = POS_W'(ctrl_q.plen);
	assign width_ext = POS_W'(ctrl_q.width);
	assign zeros     = (prec_ext > nd_ext) ? prec_ext : nd_ext;
	assign npad      = (width_ext > body_q) ? width_ext - body_q : '0;
	assign lead      = (!ctrl_q.left && !ctrl_q.zfill) ? npad : '0;
	assign zpad      = ctrl_q.zfill ? npad : '0;
	assign b3_next   = lead + zpad + body_q;

	// Pick the character at the current position
	always_comb begin
		if (pos_q < b0_q) begin
			emit_char = iff_pkg::CH_SPACE;
		end else if (pos_q < b1_q) begin
			emit_char = (pos_q == b0_q) ? ctrl_q.pre0 : ctrl_q.pre1;
		end else if (pos_q < b2_q) begin
			emit_char = iff_pkg::CH_ZERO;
		end else if (pos_q < b3_q) begin
			emit_char = iff_pkg::digit_char(rd_digit, ctrl_q.upper);
		end else begin
			emit_char = iff_pkg::CH_SPACE;
		end
	end

	assign emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = (pos_q == total_q - POS_W'(1));

	// Sequence conversion, layout and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			nd_q        <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q   <= '0;
						nd_q    <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (digit_nz) begin
						nd_q <= nd_q + 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						state_q <= ST_TALLY;
					end
				end
				ST_TALLY: begin
					// catch up on the final shift; zero still has one digit
					if (digit_nz || (nd_q == '0)) begin
						nd_q <= nd_q + 1'b1;
					end
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					state_q <= ST_BOUND;
				end
				ST_BOUND: begin
					pos_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						pos_q <= pos_q + 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold datapath and output payload
	always_ff @(posedge clk) begin
		if (emit_ok) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					ctrl_q <= q_ctrl;
					sh_q   <= q_mag;
					acc_q  <= '0;
				end
			end
			ST_CONV: begin
				acc_q <= acc_next;
				sh_q  <= {sh_q[VALUE_BITS-2:0], 1'b0};
			end
			ST_PLAN: begin
				body_q <= plen_ext + zeros;
			end
			ST_BOUND: begin
				b0_q    <= lead;
				b1_q    <= lead + plen_ext;
				b2_q    <= b3_next - nd_ext;
				b3_q    <= b3_next;
				total_q <= ctrl_q.left ? b3_next + npad : b3_next;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
